[rtl/core/arcdp_pkg.sv]
// Package for the archive record decrypt/parse core.
// Holds payload structs, operation and status codes, cipher key and record constants.
// No dependencies.
package arcdp_pkg;

	localparam logic [1:0] OP_ARCHIVE_HDR = 2'd0;
	localparam logic [1:0] OP_ENTRY_HDR   = 2'd1;
	localparam logic [1:0] OP_ENTRY_DATA  = 2'd2;
	localparam logic [1:0] OP_UNUSED      = 2'd3;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_ARCHIVE = 2'd1;
	localparam logic [1:0] ST_CORRUPT     = 2'd2;
	localparam logic [1:0] ST_BAD_FLAGS   = 2'd3;

	localparam logic [7:0]  CHAIN_BIAS = 8'h32;
	localparam logic [31:0] MAX_FILES  = 32'h0010_0000;
	localparam logic [4:0]  RECORD_LEN = 5'd28;
	localparam logic [4:0]  LAST_POS   = RECORD_LEN - 5'd1;
	localparam logic [4:0]  TAIL_POS   = 5'd8;
	localparam logic [4:0]  WORDS_END  = 5'd12;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_in;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  plain_byte;
		logic        record_done;
		logic [1:0]  status;
		logic [30:0] count_or_offset;
		logic [30:0] entry_length;
		logic        encrypted;
	} out_item_t;

	function automatic logic [7:0] key_byte(input logic [2:0] idx);
		logic [7:0] k;
		case (idx)
			3'd0: k = 8'h64;
			3'd1: k = 8'h69;
			3'd2: k = 8'h68;
			3'd3: k = 8'h6A;
			3'd4: k = 8'h79;
			3'd5: k = 8'h7E;
			3'd6: k = 8'h74;
			default: k = 8'h65;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/arcdp_channels.sv]
// Stream channel interfaces for the archive record decrypt/parse core.
// Depends on arcdp_pkg for the payload structs.
interface arcdp_in_if;
	logic                valid;
	logic                ready;
	arcdp_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface arcdp_out_if;
	logic                 valid;
	logic                 ready;
	arcdp_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[rtl/core/archive_record_decrypt_parse_core.sv]
// Archive record decrypt/parse core: top level.
// Uses arcdp_pkg, arcdp_in_if, arcdp_out_if and arcdp_engine.
//
// Channels: raw carries one archive byte per transaction (op, data_in, first);
// result carries one transaction per input byte (plain_byte, record_done,
// status, count_or_offset, entry_length, encrypted). Both use valid/ready;
// a transaction moves when valid and ready are high at a rising edge of clk.
// Header bytes are deciphered and gathered into three little-endian words;
// the 28th byte of a header record reports the record check.
// Each byte accepted on raw is held in the input register (item_s1); its result is then
// registered in result_q and shows on result from there.
// Throughput: one byte per cycle while result is not held, bounded by the
// per-byte state update of position and chain in the engine.
// Reset (arst_n low): position, chain, header words and the encrypted flag
// clear; both pipeline slots empty.
// Stall: while result is held, the result register keeps its transaction and
// the input register still takes one more byte; raw.ready then drops until
// result moves.
module archive_record_decrypt_parse_core (
	input logic         clk,
	input logic         arst_n,
	arcdp_in_if.sink    raw,
	arcdp_out_if.source result
);
	import arcdp_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      result_valid_q;
	out_item_t result_q;
	out_item_t engine_result;
	logic      advance;
	logic      load;

	assign advance   = !result_valid_q || result.ready;
	assign load      = valid_s1 && advance;
	assign raw.ready = !valid_s1 || advance;

	arcdp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.item   (item_s1),
		.result (engine_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (raw.ready) begin
				valid_s1 <= raw.valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			item_s1 <= raw.item;
		end
		if (load) begin
			result_q <= engine_result;
		end
	end

	assign result.valid = result_valid_q;
	assign result.item  = result_q;

endmodule

[rtl/core/arcdp_engine.sv]
// Decipher and header parse engine: holds position, chain, header words and flags.
// Computes one result per loaded transaction. Depends on arcdp_pkg.
module arcdp_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  arcdp_pkg::in_item_t  item,
	output arcdp_pkg::out_item_t result
);
	import arcdp_pkg::*;

	logic [4:0]  pos_q;
	logic [7:0]  chain_q;
	logic [31:0] word0_q;
	logic [31:0] word1_q;
	logic [31:0] word2_q;
	logic        tail_q;
	logic        enc_q;

	logic        restart;
	logic [4:0]  pos_eff;
	logic [7:0]  chain_eff;
	logic        is_hdr;
	logic        is_data;
	logic [4:0]  p;
	logic        do_cipher;
	logic [7:0]  plain;
	logic        nz;
	logic        tail_new;
	logic        last;
	logic [31:0] word0_n;
	logic [31:0] word1_n;
	logic [31:0] word2_n;
	logic [4:0]  pos_n;
	logic [7:0]  chain_n;
	logic        enc_n;

	always_comb begin
		restart   = (item.op != OP_UNUSED) && item.first;
		pos_eff   = restart ? 5'd0 : pos_q;
		chain_eff = restart ? 8'd0 : chain_q;
		is_hdr    = (item.op == OP_ARCHIVE_HDR) || (item.op == OP_ENTRY_HDR);
		is_data   = (item.op == OP_ENTRY_DATA);
		p         = (pos_eff >= RECORD_LEN) ? 5'd0 : pos_eff;
		do_cipher = is_hdr || (is_data && enc_q);
		plain     = do_cipher ? (item.data_in - key_byte(p[2:0]) - chain_eff) : item.data_in;
		nz        = (plain != 8'd0);
		if (p == TAIL_POS) begin
			tail_new = nz;
		end else if (p > TAIL_POS) begin
			tail_new = tail_q | nz;
		end else begin
			tail_new = tail_q;
		end
		last = is_hdr && (p == LAST_POS);

		word0_n = word0_q;
		word1_n = word1_q;
		word2_n = word2_q;
		if (is_hdr && (p < WORDS_END)) begin
			case (p[3:2])
				2'd0: word0_n[p[1:0]*8 +: 8] = plain;
				2'd1: word1_n[p[1:0]*8 +: 8] = plain;
				default: word2_n[p[1:0]*8 +: 8] = plain;
			endcase
		end

		result                 = '0;
		result.plain_byte      = plain;
		result.record_done     = last;
		enc_n                  = enc_q;
		if (last) begin
			if (item.op == OP_ARCHIVE_HDR) begin
				if ((word0_q != 32'd0) || tail_new || word1_q[31] || (word1_q > MAX_FILES)) begin
					result.status = ST_NOT_ARCHIVE;
				end else begin
					result.count_or_offset = word1_q[30:0];
				end
			end else begin
				if (word2_q[31] || word1_q[31] || nz) begin
					result.status = ST_CORRUPT;
				end else if (word0_q[31:1] != 31'd0) begin
					result.status = ST_BAD_FLAGS;
				end else begin
					result.status          = ST_OK;
					result.count_or_offset = word1_q[30:0];
					result.entry_length    = word2_q[30:0];
					result.encrypted       = word0_q[0];
					enc_n                  = word0_q[0];
				end
			end
		end

		pos_n   = pos_eff;
		chain_n = do_cipher ? (item.data_in - CHAIN_BIAS) : chain_eff;
		if (is_hdr) begin
			pos_n = last ? 5'd0 : (p + 5'd1);
			if (last) begin
				chain_n = 8'd0;
			end
		end else if (is_data && enc_q) begin
			pos_n = {2'd0, pos_eff[2:0] + 3'd1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			chain_q <= '0;
			word0_q <= '0;
			word1_q <= '0;
			word2_q <= '0;
			tail_q  <= 1'b0;
			enc_q   <= 1'b0;
		end else if (load) begin
			pos_q   <= pos_n;
			chain_q <= chain_n;
			word0_q <= word0_n;
			word1_q <= word1_n;
			word2_q <= word2_n;
			if (is_hdr) begin
				tail_q <= tail_new;
			end
			enc_q   <= enc_n;
		end
	end

endmodule

[rtl/core/arcdp_checker.sv]
// Port-level checks for archive_record_decrypt_parse_core, with its bind.
// Depends on arcdp_pkg.
module arcdp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input arcdp_pkg::out_item_t out_item
);
	import arcdp_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result transaction dropped while stalled");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.record_done |-> out_item.status == ST_OK &&
		out_item.count_or_offset == 31'd0 && out_item.entry_length == 31'd0 &&
		!out_item.encrypted)
		else $error("header fields set outside a record end");

	a_failed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.count_or_offset == 31'd0 &&
		out_item.entry_length == 31'd0 && !out_item.encrypted)
		else $error("fields set on a failed record");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind archive_record_decrypt_parse_core arcdp_checker u_arcdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_item  (result.item)
);

[test/tb_top.sv]
// Testbench for archive_record_decrypt_parse_core: streams archive and entry header records,
// entry data and stray bytes, and checks every result against a cycle-free decryptor/parser.
// Depends on arcdp_pkg, arcdp_in_if, arcdp_out_if and the core itself.
module tb_top;
	import arcdp_pkg::*;

	localparam logic [63:0] CIPHER_KEY    = "dihjy~te";
	localparam int          RANDOM_BYTES  = 480;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          HOLD_STRETCH  = 300;

	typedef logic [27:0][7:0] record_t;

	logic clk;
	logic arst_n;

	arcdp_in_if  raw_ch();
	arcdp_out_if res_ch();

	archive_record_decrypt_parse_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.result (res_ch)
	);

	logic [4:0]  pos_q;
	logic [7:0]  chain_q;
	logic [31:0] hdr_word [3];
	logic        tail_nz_q;
	logic        enc_flag_q;

	out_item_t plain_queue[$];
	int        bytes_sent;
	int        mismatches;
	int        hold_cycles;
	int        stall_left;
	bit        src_gaps;
	bit        sink_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] key_at(logic [2:0] idx);
		return CIPHER_KEY[63 - 8 * int'(idx) -: 8];
	endfunction

	function automatic logic [7:0] unscramble(logic [7:0] raw);
		logic [7:0] plain;
		plain = raw - key_at(pos_q[2:0]) - chain_q;
		chain_q = raw - CHAIN_BIAS;
		return plain;
	endfunction

	function automatic out_item_t decrypt_and_parse(in_item_t it);
		out_item_t  r;
		logic [4:0] p;
		logic [7:0] plain;
		r = '0;
		r.status = ST_OK;
		r.plain_byte = it.data_in;
		if (it.op == OP_UNUSED)
			return r;
		if (it.first) begin
			pos_q = '0;
			chain_q = '0;
		end
		if (it.op == OP_ENTRY_DATA) begin
			if (enc_flag_q) begin
				r.plain_byte = unscramble(it.data_in);
				pos_q = {2'b00, pos_q[2:0] + 3'd1};
			end
			return r;
		end
		p = (pos_q >= RECORD_LEN) ? 5'd0 : pos_q;
		plain = unscramble(it.data_in);
		r.plain_byte = plain;
		if (p < WORDS_END)
			hdr_word[p[3:2]][8 * p[1:0] +: 8] = plain;
		if (p == TAIL_POS)
			tail_nz_q = (plain != 8'h00);
		else if (p > TAIL_POS)
			tail_nz_q = tail_nz_q | (plain != 8'h00);
		if (p == LAST_POS) begin
			r.record_done = 1'b1;
			if (it.op == OP_ARCHIVE_HDR) begin
				if (hdr_word[0] != 0 || tail_nz_q || hdr_word[1][31] || hdr_word[1] > MAX_FILES)
					r.status = ST_NOT_ARCHIVE;
				else
					r.count_or_offset = hdr_word[1][30:0];
			end else if (hdr_word[2][31] || hdr_word[1][31] || plain != 8'h00) begin
				r.status = ST_CORRUPT;
			end else if (hdr_word[0][31:1] != 0) begin
				r.status = ST_BAD_FLAGS;
			end else begin
				r.count_or_offset = hdr_word[1][30:0];
				r.entry_length = hdr_word[2][30:0];
				r.encrypted = hdr_word[0][0];
				enc_flag_q = hdr_word[0][0];
			end
			pos_q = '0;
			chain_q = '0;
		end else begin
			pos_q = p + 5'd1;
		end
		return r;
	endfunction

	function automatic record_t scramble_record(record_t plain);
		record_t    cipher;
		logic [7:0] chain;
		chain = '0;
		for (int i = 0; i < 28; i++) begin
			cipher[i] = plain[i] + key_at(3'(i)) + chain;
			chain = cipher[i] - CHAIN_BIAS;
		end
		return cipher;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!src_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return {1'b1, 31'($urandom)};
			3: return 32'($urandom_range(0, 255));
			default: return {1'b0, 31'($urandom)};
		endcase
	endfunction

	function automatic logic [31:0] rand_count();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return MAX_FILES;
			2: return MAX_FILES + 32'd1;
			3: return $urandom;
			default: return 32'($urandom_range(0, MAX_FILES));
		endcase
	endfunction

	function automatic logic [31:0] rand_flags();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 32'($urandom_range(0, 1));
		if (r < 9)
			return (32'h1 << $urandom_range(1, 31)) | 32'($urandom_range(0, 1));
		return $urandom;
	endfunction

	task automatic send_byte(logic [1:0] op, logic [7:0] data, logic first);
		in_item_t it;
		int       gap;
		it.op = op;
		it.data_in = data;
		it.first = first;
		gap = pick_gap();
		if (gap > 0) begin
			raw_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.item <= it;
		@(posedge clk);
		while (!raw_ch.ready)
			@(posedge clk);
		plain_queue.push_back(decrypt_and_parse(it));
		if (op != OP_UNUSED)
			bytes_sent++;
	endtask

	task automatic send_record(logic [1:0] op, record_t rec, int nbytes, bit mix_ops);
		record_t    cipher;
		logic [1:0] op_i;
		bit         use_first;
		use_first = (pos_q != 0 || chain_q != 0) || $urandom_range(0, 3) != 0;
		cipher = scramble_record(rec);
		for (int i = 0; i < nbytes; i++) begin
			op_i = mix_ops ? 2'($urandom_range(0, 1)) : op;
			send_byte(op_i, cipher[i], i == 0 && use_first);
		end
	endtask

	task automatic send_data(int n);
		for (int i = 0; i < n; i++)
			send_byte(OP_ENTRY_DATA, 8'($urandom), i == 0 && $urandom_range(0, 4) != 0);
	endtask

	task automatic send_archive(logic [31:0] w0, logic [31:0] count, int bad_pos,
			logic [7:0] bad_val);
		record_t rec;
		rec = '0;
		rec[3:0] = w0;
		rec[7:4] = count;
		if (bad_pos >= 8)
			rec[bad_pos] = bad_val;
		send_record(OP_ARCHIVE_HDR, rec, 28, 1'b0);
	endtask

	task automatic send_entry(logic [31:0] flags, logic [31:0] offset, logic [31:0] length,
			logic [7:0] last, int ndata);
		record_t rec;
		for (int i = 12; i < 27; i++)
			rec[i] = 8'($urandom);
		rec[3:0] = flags;
		rec[7:4] = offset;
		rec[11:8] = length;
		rec[27] = last;
		send_record(OP_ENTRY_HDR, rec, 28, 1'b0);
		send_data(ndata);
	endtask

	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		while (plain_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_loose_bytes();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		send_byte(OP_UNUSED, 8'hFF, 1'b1);
		send_byte(OP_UNUSED, 8'h00, 1'b0);
		send_byte(OP_ENTRY_DATA, 8'h00, 1'b1);
		send_byte(OP_ENTRY_DATA, 8'hFF, 1'b0);
		send_byte(OP_ENTRY_DATA, 8'hA5, 1'b0);
		send_byte(OP_ARCHIVE_HDR, 8'hFF, 1'b1);
		send_byte(OP_ARCHIVE_HDR, 8'h00, 1'b0);
		send_byte(OP_ENTRY_HDR, 8'h5A, 1'b0);
		send_byte(OP_UNUSED, 8'h3C, 1'b1);
		send_byte(OP_ENTRY_HDR, 8'h11, 1'b0);
		send_byte(OP_ENTRY_DATA, 8'h81, 1'b0);
		send_byte(OP_ENTRY_HDR, 8'h7E, 1'b1);
	endtask

	task automatic test_archive_headers();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		send_archive(32'h0, 32'h0, -1, 8'h00);
		send_archive(32'h0, MAX_FILES, -1, 8'h00);
		send_archive(32'h0, MAX_FILES + 32'd1, -1, 8'h00);
		send_archive(32'h0, 32'h8000_0000, -1, 8'h00);
		send_archive(32'h0, 32'hFFFF_FFFF, -1, 8'h00);
		send_archive(32'h0000_0100, 32'd5, -1, 8'h00);
		send_archive(32'h0, 32'd3, 8, 8'h01);
		send_archive(32'h0, 32'd3, 27, 8'h80);
		send_archive(32'h0, 32'd7, 12, 8'hFF);
	endtask

	task automatic test_entry_headers();
		record_t rec;
		send_entry(32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 10);
		send_entry(32'h0, 32'h0, 32'h0, 8'h00, 4);
		send_entry(32'h1, 32'd12, 32'd34, 8'h00, 3);
		send_entry(32'h0, 32'h8000_0000, 32'd5, 8'h00, 3);
		send_entry(32'h0, 32'd5, 32'hFFFF_FFFF, 8'h00, 3);
		send_entry(32'h0, 32'd5, 32'd6, 8'h01, 2);
		send_entry(32'h2, 32'd5, 32'd6, 8'h00, 2);
		send_entry(32'hFFFF_FFFF, 32'd5, 32'd6, 8'h00, 2);
		send_entry(32'h8000_0001, 32'd5, 32'd6, 8'h00, 2);
		for (int i = 0; i < 28; i++)
			rec[i] = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom);
		send_record(OP_ENTRY_HDR, rec, 28, 1'b1);
		send_data(3);
	endtask

	task automatic test_random_stream();
		record_t rec;
		int      start;
		int      sel;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			src_gaps = $urandom_range(0, 4) != 0;
			sink_stalls = $urandom_range(0, 4) != 0;
			sel = $urandom_range(0, 99);
			for (int i = 0; i < 28; i++)
				rec[i] = 8'($urandom);
			if (sel < 15) begin
				send_archive(($urandom_range(0, 9) == 0) ? 32'h1 << $urandom_range(0, 31) : 32'h0,
					rand_count(), ($urandom_range(0, 5) == 0) ? $urandom_range(8, 27) : -1,
					8'($urandom_range(1, 255)));
			end else if (sel < 65) begin
				send_entry(rand_flags(), rand_word(), rand_word(),
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
					$urandom_range(0, 20));
			end else if (sel < 75) begin
				send_data($urandom_range(1, 12));
			end else if (sel < 85) begin
				send_record(2'($urandom_range(0, 1)), rec, $urandom_range(1, 27), 1'b0);
			end else if (sel < 92) begin
				send_record(OP_ENTRY_HDR, rec, 28, 1'b1);
			end else begin
				repeat ($urandom_range(1, 8))
					send_byte(($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2)),
						8'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_backpressure();
		src_gaps = 1'b0;
		sink_stalls = 1'b1;
		hold_cycles = HOLD_STRETCH;
		send_entry(32'h1, rand_word(), rand_word(), 8'h00, 40);
	endtask

	task automatic test_drain_pause();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		send_entry(32'h1, 32'd100, 32'd200, 8'h00, 12);
		wait_drained();
		send_data(6);
		send_archive(32'h0, rand_count(), -1, 8'h00);
		wait_drained();
		send_entry(32'h0, rand_word(), rand_word(), 8'h00, 8);
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (plain_queue.size() == 0) begin
			$display("%0t: unexpected transaction, expected none, actual %h", $time, got);
			mismatches++;
			return;
		end
		want = plain_queue.pop_front();
		compare_field("plain_byte", 32'(want.plain_byte), 32'(got.plain_byte));
		compare_field("record_done", 32'(want.record_done), 32'(got.record_done));
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("count_or_offset", 32'(want.count_or_offset), 32'(got.count_or_offset));
		compare_field("entry_length", 32'(want.entry_length), 32'(got.entry_length));
		compare_field("encrypted", 32'(want.encrypted), 32'(got.encrypted));
	endtask

	initial begin
		int r;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				check_result(res_ch.item);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ch.ready <= 1'b0;
			end else if (!sink_stalls) begin
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					res_ch.ready <= 1'b1;
				end else begin
					stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(9, 39);
					res_ch.ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		raw_ch.valid <= 1'b0;
		raw_ch.item <= '0;
		arst_n <= 1'b0;
		pos_q = '0;
		chain_q = '0;
		hdr_word[0] = '0;
		hdr_word[1] = '0;
		hdr_word[2] = '0;
		tail_nz_q = 1'b0;
		enc_flag_q = 1'b0;
		bytes_sent = 0;
		mismatches = 0;
		hold_cycles = 0;
		stall_left = 0;
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_loose_bytes();
		test_archive_headers();
		test_entry_headers();
		test_random_stream();
		test_backpressure();
		test_drain_pause();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
